>>> src/lphs_pkg.sv
// Shared types and constants for the linear-probing hash set unit.
package lphs_pkg;

    // Field widths of the transaction and configuration ports.
    localparam int unsigned KEY_W  = 31;
    localparam int unsigned SLOT_W = 10;
    localparam int unsigned CFG_W  = 11;
    localparam int unsigned MODE_W = 2;

    // Default table depth and reset value of the table size register.
    localparam int unsigned DEF_SLOT_COUNT = 1024;
    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1021;

    // Remainder unit: key bits retired per cycle.
    localparam int unsigned DIV_STEPS = 4;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_PROBE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

endpackage

>>> src/linear_probe_hash_set_unit.sv
// Top level of the linear-probing hash set unit.
// The unit keeps a set of 31-bit keys in an open-addressed table held in one RAM, where zero
// marks an empty slot. The home slot is the key modulo the configured table size; find, add and
// remove probe forward from home with wraparound, one slot per cycle, and a clear operation
// empties the whole RAM. Items are handled one at a time: a find, add or remove first passes
// the key through the remainder unit (4 key bits per cycle) and then probes P slots, where P
// runs from 1 up to the table size. Key zero skips the remainder and the search. A clear
// operation sweeps every RAM entry at one write per cycle. After reset the same sweep runs
// before the first transaction is accepted; configuration writes are taken at any time.
module linear_probe_hash_set_unit #(
    parameter int unsigned SLOT_COUNT = lphs_pkg::DEF_SLOT_COUNT,
    localparam int unsigned AW = $clog2(SLOT_COUNT),
    localparam int unsigned SW = AW + 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lphs_pkg::MODE_W-1:0] s_mode,
    input  logic [lphs_pkg::KEY_W-1:0]  s_key,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_ok,
    output logic [lphs_pkg::SLOT_W-1:0] m_slot,
    input  logic                        cfg_wr_en,
    input  logic [lphs_pkg::CFG_W-1:0]  cfg_wr_data
);
    import lphs_pkg::*;

    state_t              state_reg, state_next;
    logic                init_reg, init_next;
    logic [AW-1:0]       clr_idx_reg, clr_idx_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [SW-1:0]       size_reg, size_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic                res_ok_reg, res_ok_next;
    logic [AW-1:0]       res_slot_reg, res_slot_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_ok_reg, m_ok_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic [CFG_W-1:0]    table_size_reg;

    logic [SW-1:0]       eff_size;
    logic [SW-1:0]       inc_idx;
    logic [AW-1:0]       nxt_idx;
    logic                last_probe;
    logic                hit;
    logic                empty;
    logic [AW+SLOT_W-1:0] slot_wide;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [KEY_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_W-1:0]    ram_rdata;

    logic                div_start;
    logic                div_done;
    logic [SW-1:0]       div_rem;

    // Slot table.
    lphs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Home slot computation.
    lphs_mod #(
        .SW (SW)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_key),
        .divisor   (eff_size),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Effective table size: zero counts as one, and the size is capped at the table depth.
    always_comb begin
        priority if (table_size_reg == '0) begin
            eff_size = SW'(1);
        end else if (32'(table_size_reg) > SLOT_COUNT) begin
            eff_size = SW'(SLOT_COUNT);
        end else begin
            eff_size = SW'(table_size_reg);
        end
    end

    // Probe address arithmetic with wraparound at the table size.
    assign inc_idx    = {1'b0, cur_reg} + SW'(1);
    assign nxt_idx    = (inc_idx == size_reg) ? '0 : inc_idx[AW-1:0];
    assign last_probe = ({1'b0, cnt_reg} == (size_reg - SW'(1)));
    assign hit        = (ram_rdata == key_reg);
    assign empty      = (ram_rdata == '0);
    assign slot_wide  = {{SLOT_W{1'b0}}, res_slot_reg};

    // Sequencer: clearing sweep, remainder, probe walk and result hand-off.
    always_comb begin
        state_next    = state_reg;
        init_next     = init_reg;
        clr_idx_next  = clr_idx_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        size_next     = size_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        res_ok_next   = res_ok_reg;
        res_slot_next = res_slot_reg;
        m_valid_next  = m_valid_reg;
        m_ok_next     = m_ok_reg;
        m_slot_next   = m_slot_reg;
        ram_we        = 1'b0;
        ram_waddr     = cur_reg;
        ram_wdata     = '0;
        ram_raddr     = nxt_idx;
        div_start     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                if (clr_idx_reg == AW'(SLOT_COUNT - 1)) begin
                    init_next     = 1'b0;
                    res_ok_next   = 1'b1;
                    res_slot_next = '0;
                    state_next    = init_reg ? S_IDLE : S_DONE;
                end else begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    mode_next = s_mode;
                    key_next  = s_key;
                    size_next = eff_size;
                    priority if (s_mode == MODE_CLEAR) begin
                        clr_idx_next = '0;
                        state_next   = S_CLEAR;
                    end else if (s_key == '0) begin
                        res_ok_next   = (s_mode == MODE_ADD);
                        res_slot_next = '0;
                        state_next    = S_DONE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                ram_raddr = div_rem[AW-1:0];
                if (div_done) begin
                    cur_next   = div_rem[AW-1:0];
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                unique case (mode_reg)
                    MODE_ADD: begin
                        // Insert at the first empty slot; duplicates seen at home only.
                        priority if (empty) begin
                            ram_we        = 1'b1;
                            ram_wdata     = key_reg;
                            res_ok_next   = 1'b1;
                            res_slot_next = cur_reg;
                            state_next    = S_DONE;
                        end else if ((cnt_reg == '0) && hit) begin
                            res_ok_next   = 1'b1;
                            res_slot_next = cur_reg;
                            state_next    = S_DONE;
                        end else if (last_probe) begin
                            res_ok_next   = 1'b0;
                            res_slot_next = '0;
                            state_next    = S_DONE;
                        end else begin
                            cur_next = nxt_idx;
                            cnt_next = cnt_reg + AW'(1);
                        end
                    end
                    MODE_FIND, MODE_REMOVE: begin
                        // Lookup stops at the first empty slot; remove clears the hit.
                        priority if (empty) begin
                            res_ok_next   = 1'b0;
                            res_slot_next = '0;
                            state_next    = S_DONE;
                        end else if (hit) begin
                            ram_we        = (mode_reg == MODE_REMOVE);
                            res_ok_next   = 1'b1;
                            res_slot_next = cur_reg;
                            state_next    = S_DONE;
                        end else if (last_probe) begin
                            res_ok_next   = 1'b0;
                            res_slot_next = '0;
                            state_next    = S_DONE;
                        end else begin
                            cur_next = nxt_idx;
                            cnt_next = cnt_reg + AW'(1);
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_slot_next  = slot_wide[SLOT_W-1:0];
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            init_reg       <= 1'b1;
            clr_idx_reg    <= '0;
            m_valid_reg    <= 1'b0;
            table_size_reg <= TABLE_SIZE_RST;
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                table_size_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        size_reg     <= size_next;
        cur_reg      <= cur_next;
        cnt_reg      <= cnt_next;
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        m_ok_reg     <= m_ok_next;
        m_slot_reg   <= m_slot_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_ok    = m_ok_reg;
    assign m_slot  = m_slot_reg;

endmodule

>>> src/lphs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lphs_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/lphs_mod.sv
// Multi-cycle remainder unit: key modulo table size, several bits per cycle.
module lphs_mod #(
    parameter int unsigned SW = 11
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lphs_pkg::KEY_W-1:0] dividend,
    input  logic [SW-1:0]              divisor,
    output logic                       done,
    output logic [SW-1:0]              remainder
);
    import lphs_pkg::*;

    localparam int unsigned DIV_CYCLES = (KEY_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int unsigned PAD_W = DIV_CYCLES * DIV_STEPS;
    localparam int unsigned CW = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [PAD_W-1:0] quo_reg;
    logic [SW-1:0]    rem_reg;
    logic [SW-1:0]    div_reg;
    logic [SW:0]      step_r;
    logic [SW-1:0]    rem_next;

    // Restoring remainder steps for the top bits of the shifted dividend.
    always_comb begin
        step_r = {1'b0, rem_reg};
        for (int k = 0; k < DIV_STEPS; k++) begin
            step_r = {step_r[SW-1:0], quo_reg[PAD_W-1-k]};
            if (step_r >= {1'b0, div_reg}) begin
                step_r = step_r - {1'b0, div_reg};
            end
        end
        rem_next = step_r[SW-1:0];
    end

    // Control: busy while bits remain, done pulses once the remainder is final.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= {{(PAD_W - KEY_W){1'b0}}, dividend};
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_reg << DIV_STEPS;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> verif/linear_probe_hash_set_unit_test.sv
// Self-checking testbench for the linear-probing hash set unit.
module linear_probe_hash_set_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lphs_pkg::*;

    localparam int unsigned SLOTS = DEF_SLOT_COUNT;

    // One expected answer from the set.
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
    } set_reply_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [MODE_W-1:0] s_mode = MODE_FIND;
    logic [KEY_W-1:0]  s_key = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_ok;
    logic [SLOT_W-1:0] m_slot;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;

    // Shadow copy of the table and the size register.
    logic [KEY_W-1:0] shadow_slots [SLOTS];
    logic [CFG_W-1:0] shadow_size;

    set_reply_t       replies_due [$];
    logic [KEY_W-1:0] recent_keys [$];
    int               mismatch_count = 0;
    int               ready_hold = 0;
    bit               calm_phase = 1'b0;

    linear_probe_hash_set_unit #(
        .SLOT_COUNT (SLOTS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_key       (s_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ok        (m_ok),
        .m_slot      (m_slot),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Table size as the hardware sees it: zero counts as one, clamped to the depth.
    function automatic int unsigned shadow_span();
        if (shadow_size == 0) return 1;
        if (shadow_size > SLOTS) return SLOTS;
        return shadow_size;
    endfunction

    // Probe from the home slot; the walk ends at the first empty slot.
    function automatic bit find_in_shadow(input logic [KEY_W-1:0] key,
                                          input int unsigned span,
                                          output int unsigned where);
        int unsigned home;
        int unsigned idx;
        int unsigned i;
        home = key % span;
        where = 0;
        for (i = 0; i < span; i++) begin
            idx = home + i;
            if (idx >= span) idx -= span;
            if (shadow_slots[idx] == 0) return 1'b0;
            if (shadow_slots[idx] == key) begin
                where = idx;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one operation to the shadow table and return the answer it should give.
    function automatic set_reply_t predict_set_reply(input logic [MODE_W-1:0] mode,
                                                     input logic [KEY_W-1:0] key);
        set_reply_t  reply;
        int unsigned span;
        int unsigned home;
        int unsigned idx;
        int unsigned where;
        int unsigned i;
        reply = '0;
        span = shadow_span();
        case (mode)
            MODE_FIND: begin
                if (key != 0 && find_in_shadow(key, span, where)) begin
                    reply.ok = 1'b1;
                    reply.slot = where[SLOT_W-1:0];
                end
            end
            MODE_ADD: begin
                if (key == 0) begin
                    reply.ok = 1'b1;
                end else begin
                    // Duplicates are caught at the home slot only.
                    home = key % span;
                    if (shadow_slots[home] == 0 || shadow_slots[home] == key) begin
                        shadow_slots[home] = key;
                        reply.ok = 1'b1;
                        reply.slot = home[SLOT_W-1:0];
                    end
                    for (i = 1; i < span && !reply.ok; i++) begin
                        idx = home + i;
                        if (idx >= span) idx -= span;
                        if (shadow_slots[idx] == 0) begin
                            shadow_slots[idx] = key;
                            reply.ok = 1'b1;
                            reply.slot = idx[SLOT_W-1:0];
                        end
                    end
                end
            end
            MODE_REMOVE: begin
                if (key != 0 && find_in_shadow(key, span, where)) begin
                    shadow_slots[where] = '0;
                    reply.ok = 1'b1;
                    reply.slot = where[SLOT_W-1:0];
                end
            end
            default: begin
                for (i = 0; i < SLOTS; i++) shadow_slots[i] = '0;
                reply.ok = 1'b1;
            end
        endcase
        return reply;
    endfunction

    // Send one transaction; valid is held until it is accepted.
    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key);
        int idle_cycles;
        idle_cycles = pick_gap();
        if (idle_cycles > 0) begin
            s_valid <= 1'b0;
            repeat (idle_cycles) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_key <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        replies_due.push_back(predict_set_reply(mode, key));
        if (mode == MODE_ADD && key != 0) begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 64) void'(recent_keys.pop_front());
        end
    endtask

    // Let the unit drain, then write the table size register.
    task automatic set_table_size(input logic [CFG_W-1:0] value);
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        shadow_size = value;
    endtask

    // Key zero, home collisions, wraparound, the probe gap left by a remove, clamping of
    // the size register and keys hidden beyond a shrunken table.
    task automatic test_directed();
        send_op(MODE_ADD, '0);
        send_op(MODE_FIND, '0);
        send_op(MODE_REMOVE, '0);
        send_op(MODE_ADD, 31'd1021);
        send_op(MODE_ADD, 31'd2042);
        send_op(MODE_ADD, 31'd1020);
        send_op(MODE_ADD, 31'd2041);
        send_op(MODE_ADD, 31'h7FFF_FFFF);
        send_op(MODE_FIND, 31'h7FFF_FFFF);
        send_op(MODE_REMOVE, 31'd2042);
        send_op(MODE_FIND, 31'd2041);
        send_op(MODE_ADD, 31'd1021);

        // A size of zero behaves as a single slot, which is already taken.
        set_table_size(11'd0);
        send_op(MODE_ADD, 31'd5);
        send_op(MODE_FIND, 31'd1021);

        // An oversized register clamps to the full depth; home at the last slot wraps.
        set_table_size(11'd2047);
        send_op(MODE_ADD, 31'd2047);
        send_op(MODE_ADD, 31'd3071);
        send_op(MODE_FIND, 31'd3071);

        // A small table sees only its first slots and fills at once.
        set_table_size(11'd3);
        send_op(MODE_FIND, 31'd2041);
        send_op(MODE_ADD, 31'd9);

        // Growing again brings the untouched upper slots back into view.
        set_table_size(TABLE_SIZE_RST);
        send_op(MODE_FIND, 31'd1020);
        send_op(MODE_CLEAR, 31'h5555_5555);
        send_op(MODE_FIND, 31'd1020);
    endtask

    // Random operations over a range of table sizes, with keys chosen to collide.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] sizes [11];
        int unsigned      span;
        int               phase;
        int               n;
        int               r;
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        sizes = '{11'd1, 11'd2, 11'd0, 11'd5, 11'd7, 11'd2047, 11'd13, 11'd1024,
                  11'd97, 11'd1021, 11'd0};
        sizes[10] = CFG_W'($urandom_range(1, 2047));
        for (phase = 0; phase < 11; phase++) begin
            set_table_size(sizes[phase]);
            calm_phase = (phase % 4 == 3);
            span = shadow_span();
            for (n = 0; n < 48; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4) mode = MODE_CLEAR;
                else if (r < 45) mode = MODE_ADD;
                else if (r < 75) mode = MODE_FIND;
                else mode = MODE_REMOVE;
                r = $urandom_range(0, 99);
                if (r < 3) key = '0;
                else if (r < 8) key = KEY_W'($urandom());
                else if (r < 40 && recent_keys.size() > 0)
                    key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                else key = KEY_W'($urandom_range(1, 3 * span + 2));
                send_op(mode, key);
            end
        end
        calm_phase = 1'b0;
    endtask

    // Result side stalls: short runs of ready with random gaps between them.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    // Compare each result transaction with the oldest expected answer.
    always @(posedge aclk) begin : result_check
        set_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: result with none expected, ok=%0b slot=%0d",
                         $time, m_ok, m_slot);
                mismatch_count++;
            end else begin
                want = replies_due.pop_front();
                if (m_ok !== want.ok) begin
                    $display("%0t: ok expected %0b, got %0b", $time, want.ok, m_ok);
                    mismatch_count++;
                end
                if (m_slot !== want.slot) begin
                    $display("%0t: slot expected %0d, got %0d", $time, want.slot, m_slot);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        for (int i = 0; i < SLOTS; i++) shadow_slots[i] = '0;
        shadow_size = TABLE_SIZE_RST;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_traffic();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
